>>> hdl/mmp_pkg.sv
package mmp_pkg;

  localparam int unsigned MAX_DIM = 4;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned DIM_W   = 3;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned EXP_W   = 63;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PROD_W  = 2 * VAL_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_ADDR_W = 1;

  localparam logic [VAL_W-1:0] MODULUS_RST = 31'd1000000007;
  localparam logic [DIM_W-1:0] SIZE_RST    = 3'd4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODULUS = 1'b0,
    CFG_SIZE    = 1'b1
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_MAT = 2'd0,
    KIND_LOAD_VEC = 2'd1,
    KIND_POWER    = 2'd2,
    KIND_VECTOR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_MULT = 2'd1,
    OP_SQR  = 2'd2,
    OP_VEC  = 2'd3
  } op_sel_e;

  typedef struct packed {
    logic             load_in;
    logic             init_pow;
    logic             mac_start;
    logic             acc_clr;
    op_sel_e          op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             tmp_wr;
    logic             copy_p;
    logic             copy_s;
    logic             shift_exp;
    logic             store_base;
    logic             store_vec;
    logic             out_load;
    logic             out_src_acc;
    logic             out_last;
  } mmp_cmd_t;

  typedef struct packed {
    logic             mac_done;
    logic             exp_zero;
    logic             exp_lsb;
    logic             out_free;
    logic [DIM_W-1:0] n;
  } mmp_stat_t;

endpackage

>>> hdl/mmp_modmul.sv
module mmp_modmul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mmp_pkg::VAL_W-1:0] a_i,
  input  logic [mmp_pkg::VAL_W-1:0] b_i,
  input  logic [mmp_pkg::VAL_W-1:0] acc_i,
  input  logic [mmp_pkg::VAL_W-1:0] mod_i,
  output logic                      done_o,
  output logic [mmp_pkg::VAL_W-1:0] res_o
);
  import mmp_pkg::*;

  logic [SUM_W-1:0]  x_q;
  logic [VAL_W-1:0]  r_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [PROD_W-1:0] prod;
  logic [VAL_W:0]    shifted;
  logic [VAL_W:0]    reduced;

  assign prod    = PROD_W'(a_i) * PROD_W'(b_i);
  assign shifted = {r_q, x_q[SUM_W-1]};
  assign reduced = (shifted >= {1'b0, mod_i}) ? shifted - {1'b0, mod_i} : shifted;

  // one bit of the sum per cycle, msb first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= SUM_W'(prod) + SUM_W'(acc_i);
      r_q <= '0;
    end else if (busy_q) begin
      x_q <= {x_q[SUM_W-2:0], 1'b0};
      r_q <= reduced[VAL_W-1:0];
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

>>> hdl/mmp_datapath.sv
module mmp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mmp_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [mmp_pkg::VAL_W-1:0]      cfg_wdata_i,
  input  logic [mmp_pkg::IDX_W-1:0]      in_row_i,
  input  logic [mmp_pkg::IDX_W-1:0]      in_col_i,
  input  logic [mmp_pkg::VAL_W-1:0]      in_value_i,
  input  logic [mmp_pkg::EXP_W-1:0]      in_exponent_i,
  input  mmp_pkg::mmp_cmd_t              cmd_i,
  output mmp_pkg::mmp_stat_t             stat_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [mmp_pkg::IDX_W-1:0]      out_row_o,
  output logic [mmp_pkg::IDX_W-1:0]      out_col_o,
  output logic [mmp_pkg::VAL_W-1:0]      out_value_o,
  output logic                           out_last_o
);
  import mmp_pkg::*;

  logic [VAL_W-1:0] modulus_q;
  logic [DIM_W-1:0] size_q;
  logic [VAL_W-1:0] m_eff;
  logic [DIM_W-1:0] n;

  logic [VAL_W-1:0] base_q [MAX_DIM][MAX_DIM];
  logic [VAL_W-1:0] vec_q  [MAX_DIM];
  logic [VAL_W-1:0] pow_q  [MAX_DIM][MAX_DIM];
  logic [VAL_W-1:0] sq_q   [MAX_DIM][MAX_DIM];
  logic [VAL_W-1:0] tmp_q  [MAX_DIM][MAX_DIM];

  logic [IDX_W-1:0] row_q;
  logic [IDX_W-1:0] col_q;
  logic [VAL_W-1:0] value_q;
  logic [EXP_W-1:0] exp_q;
  logic [VAL_W-1:0] acc_q;

  logic [VAL_W-1:0] op_a;
  logic [VAL_W-1:0] op_b;
  logic [VAL_W-1:0] op_acc;
  logic             mac_done;
  logic [VAL_W-1:0] mac_res;
  logic [VAL_W-1:0] one_mod;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_row_q;
  logic [IDX_W-1:0] out_col_q;
  logic [VAL_W-1:0] out_value_q;
  logic             out_last_q;

  assign m_eff   = (modulus_q == '0) ? VAL_W'(1) : modulus_q;
  assign one_mod = (m_eff == VAL_W'(1)) ? '0 : VAL_W'(1);

  always_comb begin
    if (size_q == '0) begin
      n = DIM_W'(1);
    end else if (size_q > DIM_W'(MAX_DIM)) begin
      n = DIM_W'(MAX_DIM);
    end else begin
      n = size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
      size_q    <= SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_MODULUS: modulus_q <= cfg_wdata_i;
        CFG_SIZE:    size_q    <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_MULT: begin
        op_a = pow_q[cmd_i.i][cmd_i.k];
        op_b = sq_q[cmd_i.k][cmd_i.j];
      end
      OP_SQR: begin
        op_a = sq_q[cmd_i.i][cmd_i.k];
        op_b = sq_q[cmd_i.k][cmd_i.j];
      end
      OP_VEC: begin
        op_a = vec_q[cmd_i.k];
        op_b = pow_q[cmd_i.k][cmd_i.i];
      end
      default: begin
        op_a = value_q;
        op_b = VAL_W'(1);
      end
    endcase
  end

  assign op_acc = cmd_i.acc_clr ? '0 : acc_q;

  mmp_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mac_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .acc_i   (op_acc),
    .mod_i   (m_eff),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      row_q   <= in_row_i;
      col_q   <= in_col_i;
      value_q <= in_value_i;
      exp_q   <= in_exponent_i;
    end else if (cmd_i.shift_exp) begin
      exp_q <= exp_q >> 1;
    end
    if (mac_done) begin
      acc_q <= mac_res;
    end
    if (cmd_i.tmp_wr) begin
      tmp_q[cmd_i.i][cmd_i.j] <= mac_res;
    end
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        if (DIM_W'(r) < n && DIM_W'(c) < n) begin
          if (cmd_i.init_pow) begin
            sq_q[r][c] <= base_q[r][c];
          end else if (cmd_i.copy_s) begin
            sq_q[r][c] <= tmp_q[r][c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_DIM; r++) begin
        vec_q[r] <= '0;
        for (int c = 0; c < MAX_DIM; c++) begin
          base_q[r][c] <= '0;
          pow_q[r][c]  <= (r == c) ? VAL_W'(1) : '0;
        end
      end
    end else begin
      if (cmd_i.store_base) begin
        base_q[row_q][col_q] <= mac_res;
      end
      if (cmd_i.store_vec) begin
        vec_q[col_q] <= mac_res;
      end
      for (int r = 0; r < MAX_DIM; r++) begin
        for (int c = 0; c < MAX_DIM; c++) begin
          if (DIM_W'(r) < n && DIM_W'(c) < n) begin
            if (cmd_i.init_pow) begin
              pow_q[r][c] <= (r == c) ? one_mod : '0;
            end else if (cmd_i.copy_p) begin
              pow_q[r][c] <= tmp_q[r][c];
            end
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_row_q   <= cmd_i.out_src_acc ? '0 : cmd_i.i;
      out_col_q   <= cmd_i.out_src_acc ? cmd_i.i : cmd_i.j;
      out_value_q <= cmd_i.out_src_acc ? acc_q : pow_q[cmd_i.i][cmd_i.j];
      out_last_q  <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  assign stat_o.mac_done = mac_done;
  assign stat_o.exp_zero = (exp_q == '0);
  assign stat_o.exp_lsb  = exp_q[0];
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.n        = n;

endmodule

>>> hdl/mmp_ctrl.sv
module mmp_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mmp_pkg::KIND_W-1:0]  in_kind_i,
  input  mmp_pkg::mmp_stat_t          stat_i,
  output mmp_pkg::mmp_cmd_t           cmd_o
);
  import mmp_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_LDSTART = 9'b000000010,
    ST_LDWAIT  = 9'b000000100,
    ST_CHECK   = 9'b000001000,
    ST_MSTART  = 9'b000010000,
    ST_MWAIT   = 9'b000100000,
    ST_COPY    = 9'b001000000,
    ST_EMIT    = 9'b010000000,
    ST_VEMIT   = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  op_sel_e          mode_q, mode_d;
  logic             did_mult_q, did_mult_d;
  logic             ld_vec_q, ld_vec_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IDX_W-1:0] nm1;
  logic             accept;

  assign nm1        = IDX_W'(stat_i.n - DIM_W'(1));
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= OP_LOAD;
      did_mult_q <= 1'b0;
      ld_vec_q   <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      did_mult_q <= did_mult_d;
      ld_vec_q   <= ld_vec_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    did_mult_d = did_mult_q;
    ld_vec_d   = ld_vec_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    cmd_o      = '0;
    cmd_o.op   = mode_q;
    cmd_o.i    = i_q;
    cmd_o.j    = j_q;
    cmd_o.k    = k_q;

    case (state_q)
      ST_IDLE: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
        did_mult_d = 1'b0;
        if (accept) begin
          cmd_o.load_in = 1'b1;
          case (kind_e'(in_kind_i))
            KIND_LOAD_MAT: begin
              ld_vec_d = 1'b0;
              mode_d   = OP_LOAD;
              state_d  = ST_LDSTART;
            end
            KIND_LOAD_VEC: begin
              ld_vec_d = 1'b1;
              mode_d   = OP_LOAD;
              state_d  = ST_LDSTART;
            end
            KIND_POWER: begin
              cmd_o.init_pow = 1'b1;
              state_d        = ST_CHECK;
            end
            default: begin
              mode_d  = OP_VEC;
              state_d = ST_MSTART;
            end
          endcase
        end
      end
      ST_LDSTART: begin
        cmd_o.mac_start = 1'b1;
        cmd_o.acc_clr   = 1'b1;
        state_d         = ST_LDWAIT;
      end
      ST_LDWAIT: begin
        if (stat_i.mac_done) begin
          cmd_o.store_base = !ld_vec_q;
          cmd_o.store_vec  = ld_vec_q;
          state_d          = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (stat_i.exp_zero) begin
          state_d = ST_EMIT;
        end else if (stat_i.exp_lsb && !did_mult_q) begin
          mode_d  = OP_MULT;
          state_d = ST_MSTART;
        end else begin
          mode_d  = OP_SQR;
          state_d = ST_MSTART;
        end
      end
      ST_MSTART: begin
        cmd_o.mac_start = 1'b1;
        cmd_o.acc_clr   = (k_q == '0);
        state_d         = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (stat_i.mac_done) begin
          state_d = ST_MSTART;
          if (k_q == nm1) begin
            k_d = '0;
            if (mode_q == OP_VEC) begin
              state_d = ST_VEMIT;
            end else begin
              cmd_o.tmp_wr = 1'b1;
              if (j_q == nm1) begin
                j_d = '0;
                if (i_q == nm1) begin
                  i_d     = '0;
                  state_d = ST_COPY;
                end else begin
                  i_d = i_q + 1'b1;
                end
              end else begin
                j_d = j_q + 1'b1;
              end
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_COPY: begin
        if (mode_q == OP_MULT) begin
          cmd_o.copy_p = 1'b1;
          did_mult_d   = 1'b1;
        end else begin
          cmd_o.copy_s    = 1'b1;
          cmd_o.shift_exp = 1'b1;
          did_mult_d      = 1'b0;
        end
        state_d = ST_CHECK;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (i_q == nm1) && (j_q == nm1);
          if (j_q == nm1) begin
            j_d = '0;
            if (i_q == nm1) begin
              i_d     = '0;
              state_d = ST_IDLE;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      ST_VEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_src_acc = 1'b1;
          cmd_o.out_last    = (i_q == nm1);
          if (i_q == nm1) begin
            i_d     = '0;
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_MSTART;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/modular_matrix_power.sv
// Modular matrix power. Kind 0 and 1 requests load one matrix or vector entry,
// reduced by the modulus. A kind 2 request raises the loaded n x n matrix to a
// 63-bit exponent by square-and-multiply and returns n*n entries row by row,
// tlast on the final one; a kind 3 request returns the stored vector times the
// last power result, n entries. All arithmetic runs through one shared
// multiply-reduce unit: one multiply, then one bit of reduction per cycle over
// the 63-bit sum. A power request performs one matrix product per squaring plus
// one per set bit of the exponent, up to 126 products, then emits its entries,
// held back while the output is stalled. Input is taken only between requests;
// results drain through an output register.
module modular_matrix_power (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mmp_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [mmp_pkg::VAL_W-1:0]          cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // row, col, value, exponent, zero pad
  input  logic [mmp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // kind
  input  logic [mmp_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_row, out_col, out_value, zero pad
  output logic [mmp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast
);
  import mmp_pkg::*;

  mmp_cmd_t         cmd;
  mmp_stat_t        stat;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic [VAL_W-1:0] out_value;

  mmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mmp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_row_i      (s_axis_tdata[1:0]),
    .in_col_i      (s_axis_tdata[3:2]),
    .in_value_i    (s_axis_tdata[34:4]),
    .in_exponent_i (s_axis_tdata[97:35]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_value_o   (out_value),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_value, out_col, out_row};

endmodule
